>>> rtl/lzw_pkg.sv
// Shared constants, types and state encoding for the LZW encoder.
package lzw_pkg;

    localparam int LZW_DICT_ENTRIES = 4096;
    localparam int LZW_FIRST_CODE   = 256;
    localparam int LZW_BYTE_W       = 8;
    localparam int LZW_CODE_OUT_W   = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_SLOT,
        ST_RD_DICT,
        ST_EMIT,
        ST_FIN
    } lzw_state_t;

    typedef struct packed {
        logic [LZW_CODE_OUT_W-1:0] out_code;
        logic                      final_code;
    } lzw_beat_t;

endpackage

>>> rtl/lzw_byte_if.sv
// Byte input channel: valid/ready handshake carrying one message byte per beat.
interface lzw_byte_if;
    import lzw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LZW_BYTE_W-1:0] data_byte;
    logic                  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/lzw_code_if.sv
// Code output channel: valid/ready handshake carrying one emitted code per beat.
interface lzw_code_if;
    import lzw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [LZW_CODE_OUT_W-1:0] out_code;
    logic                      final_code;

    modport source (output valid, output out_code, output final_code, input ready);
    modport sink   (input valid, input out_code, input final_code, output ready);
endinterface

>>> rtl/lzw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/lzw_out_reg.sv
// Output register stage: holds one code beat until the sink takes it.
module lzw_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lzw_pkg::lzw_beat_t beat,
    output logic              free,
    lzw_code_if.source        codes
);
    import lzw_pkg::*;

    logic      valid_reg;
    lzw_beat_t beat_reg;

    assign free = !valid_reg || codes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (codes.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload: no reset, load only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat;
        end
    end

    assign codes.valid      = valid_reg;
    assign codes.out_code   = beat_reg.out_code;
    assign codes.final_code = beat_reg.final_code;
endmodule

>>> rtl/lzw_encoder_12bit.sv
// LZW encoder top level: hashed dictionary in two RAMs, probe sequencer, output register.
// Sequence: each byte after the first of a message starts a probe of the hash table, a slot
//   RAM read and then a dictionary RAM read at the code found there; a hit ends the probe,
//   a live slot that misses steps to the next slot, and a free slot is claimed and leads to
//   an emit state that waits while the output register is full. One byte in flight at a time.
// Reset: control state cleared at once (no prefix, next code 256); neither RAM is cleared
//   and no clearing pass runs, since stale slots are rejected by the back-pointer check.
module lzw_encoder_12bit #(
    parameter int DICT_ENTRIES = lzw_pkg::LZW_DICT_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    lzw_byte_if.sink   bytes,
    lzw_code_if.source codes
);
    import lzw_pkg::*;

    // Code width, hash table index width (table twice the dictionary so it never fills),
    // key width and dictionary entry width (key plus the slot that points back at it).
    localparam int CW = $clog2(DICT_ENTRIES);
    localparam int HW = CW + 1;
    localparam int HS = 2 ** HW;
    localparam int KW = CW + LZW_BYTE_W;
    localparam int DW = KW + HW;

    lzw_state_t state_reg, state_next;

    logic [CW-1:0]         prefix_reg;
    logic                  prefix_valid_reg;
    logic [CW-1:0]         next_code_reg;
    logic [LZW_BYTE_W-1:0] byte_reg;
    logic                  last_reg;
    logic [HW-1:0]         slot_reg;
    logic [CW-1:0]         cand_reg;
    logic [CW-1:0]         emit_reg;

    logic          in_acc;
    logic [HW-1:0] hash;

    // hash table RAM: slot -> code
    logic          s_we;
    logic [HW-1:0] s_raddr;
    logic [CW-1:0] s_rdata;

    // dictionary RAM: code -> {prefix, byte, home slot}
    logic          d_we;
    logic [DW-1:0] d_wdata;
    logic [DW-1:0] d_rdata;
    logic [KW-1:0] d_key;
    logic [HW-1:0] d_slot;

    logic live;
    logic hit;

    logic                       out_load;
    logic                       out_free;
    lzw_beat_t                  out_beat;
    logic [CW+LZW_CODE_OUT_W-1:0] code_ext;

    assign in_acc      = bytes.valid && bytes.ready;
    assign bytes.ready = (state_reg == ST_IDLE);

    // Fold the byte into the top bits of the prefix; the probe steps linearly from here.
    assign hash = {1'b0, prefix_reg} ^ {bytes.data_byte, {(HW - LZW_BYTE_W){1'b0}}};

    assign d_key  = d_rdata[DW-1:HW];
    assign d_slot = d_rdata[HW-1:0];

    // A slot is live only if its code belongs to the current dictionary and that
    // code's entry points back at this very slot; anything else is free to take.
    always_comb
    begin
        live = 1'b0;
        hit  = 1'b0;
        if ((cand_reg >= CW'(LZW_FIRST_CODE)) && (cand_reg < next_code_reg)
            && (d_slot == slot_reg))
        begin
            live = 1'b1;
            if (d_key == {prefix_reg, byte_reg})
            begin
                hit = 1'b1;
            end
        end
    end

    lzw_ram #(
        .WIDTH (CW),
        .DEPTH (HS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (slot_reg),
        .wdata (next_code_reg),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    lzw_ram #(
        .WIDTH (DW),
        .DEPTH (DICT_ENTRIES)
    ) u_dict_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (next_code_reg),
        .wdata (d_wdata),
        .raddr (s_rdata),
        .rdata (d_rdata)
    );

    lzw_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .beat  (out_beat),
        .free  (out_free),
        .codes (codes)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!prefix_valid_reg)
                    begin
                        state_next = bytes.last_byte ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD_SLOT;
                    end
                end
            end
            ST_RD_SLOT:
            begin
                state_next = ST_RD_DICT;
            end
            ST_RD_DICT:
            begin
                if (hit)
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
                else if (live)
                begin
                    state_next = ST_RD_SLOT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: RAM ports and output register load
    always_comb
    begin
        s_raddr  = slot_reg;
        s_we     = 1'b0;
        d_we     = 1'b0;
        d_wdata  = {prefix_reg, byte_reg, slot_reg};
        out_load = 1'b0;
        code_ext = {{LZW_CODE_OUT_W{1'b0}}, prefix_reg};
        out_beat = '{out_code: code_ext[LZW_CODE_OUT_W-1:0], final_code: 1'b1};
        case (state_reg)
            ST_IDLE:
            begin
                s_raddr = hash;
            end
            ST_RD_SLOT:
            begin
                s_raddr = slot_reg;
            end
            ST_RD_DICT:
            begin
                // step on to the next slot; on a miss claim this free slot
                s_raddr = slot_reg + HW'(1);
                if (!live)
                begin
                    s_we = 1'b1;
                    d_we = 1'b1;
                end
            end
            ST_EMIT:
            begin
                code_ext = {{LZW_CODE_OUT_W{1'b0}}, emit_reg};
                out_beat = '{out_code: code_ext[LZW_CODE_OUT_W-1:0], final_code: 1'b0};
                out_load = out_free;
            end
            ST_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_code_reg    <= CW'(LZW_FIRST_CODE);
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !prefix_valid_reg)
                    begin
                        prefix_reg       <= CW'(bytes.data_byte);
                        prefix_valid_reg <= 1'b1;
                    end
                end
                ST_RD_DICT:
                begin
                    if (hit)
                    begin
                        prefix_reg <= cand_reg;
                    end
                    else if (!live)
                    begin
                        // restart from the byte; wrap drops every learned entry
                        prefix_reg <= CW'(byte_reg);
                        if (next_code_reg == CW'(DICT_ENTRIES - 1))
                        begin
                            next_code_reg <= CW'(LZW_FIRST_CODE);
                        end
                        else
                        begin
                            next_code_reg <= next_code_reg + CW'(1);
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        prefix_reg       <= '0;
                        prefix_valid_reg <= 1'b0;
                        next_code_reg    <= CW'(LZW_FIRST_CODE);
                    end
                end
                default:
                begin
                    prefix_valid_reg <= prefix_valid_reg;
                end
            endcase
        end
    end

    // Working registers of the current byte; no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    byte_reg <= bytes.data_byte;
                    last_reg <= bytes.last_byte;
                    slot_reg <= hash;
                end
            end
            ST_RD_SLOT:
            begin
                cand_reg <= s_rdata;
            end
            ST_RD_DICT:
            begin
                if (!hit && live)
                begin
                    slot_reg <= slot_reg + HW'(1);
                end
                emit_reg <= prefix_reg;
            end
            default:
            begin
                cand_reg <= cand_reg;
            end
        endcase
    end

    // Next code always stays within the learned range
    a_next_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_code_reg >= CW'(LZW_FIRST_CODE))
        && ({1'b0, next_code_reg} < (CW + 1)'(DICT_ENTRIES)))
        else $error("next code out of range");

    // A hit adopts a code of the current dictionary
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_DICT && hit)
        |=> (prefix_reg >= CW'(LZW_FIRST_CODE)) && (prefix_reg < next_code_reg))
        else $error("hit code outside current dictionary");

    // Closing code resets the dictionary and drops the prefix
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free)
        |=> !prefix_valid_reg && (next_code_reg == CW'(LZW_FIRST_CODE)))
        else $error("closing code did not reset the dictionary");

    // Never overwrite a beat the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!codes.valid || codes.ready))
        else $error("output beat overwritten");

    // Dictionary writes come only with a slot write on a miss, never at a byte accept
    a_write_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        d_we |-> (!in_acc && s_we && state_next == ST_EMIT))
        else $error("dictionary write outside miss handling");
endmodule

>>> bench/lzw_code_checker.sv
`timescale 1ns / 1ps
// Passive checker for the LZW encoder: predicts codes from accepted bytes and compares them.
module lzw_code_checker (
    input  logic clk,
    input  logic rst_n,
    lzw_byte_if  bytes,
    lzw_code_if  codes,
    output int   fail_count,
    output int   outstanding
);
    import lzw_pkg::*;

    localparam int DICT_LIMIT = LZW_DICT_ENTRIES;

    logic [LZW_CODE_OUT_W-1:0] prefix;
    logic                      prefix_held;
    int                        free_code;
    logic [LZW_CODE_OUT_W-1:0] learned [bit [19:0]];
    lzw_beat_t                 expected_codes [$];
    int                        beat_index;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at code beat %0d: %s", beat_index, what);
        fail_count++;
    endtask

    function automatic void push_code(input logic [LZW_CODE_OUT_W-1:0] code, input logic fin);
        lzw_beat_t beat;
        beat.out_code   = code;
        beat.final_code = fin;
        expected_codes.insert(expected_codes.size(), beat);
    endfunction

    // Advance the dictionary by one byte and queue whatever codes it emits.
    function automatic void encode_byte(input logic [LZW_BYTE_W-1:0] b, input logic l);
        bit [19:0] key;
        if (!prefix_held)
        begin
            prefix      = {4'h0, b};
            prefix_held = 1'b1;
        end
        else
        begin
            key = {prefix, b};
            if (learned.exists(key))
            begin
                prefix = learned[key];
            end
            else
            begin
                push_code(prefix, 1'b0);
                if (free_code < DICT_LIMIT)
                    learned[key] = free_code[LZW_CODE_OUT_W-1:0];
                free_code++;
                // full dictionary: drop every learned pair, the new one too
                if (free_code >= DICT_LIMIT)
                begin
                    free_code = LZW_FIRST_CODE;
                    learned.delete();
                end
                prefix = {4'h0, b};
            end
        end
        if (l)
        begin
            push_code(prefix, 1'b1);
            prefix      = '0;
            prefix_held = 1'b0;
            free_code   = LZW_FIRST_CODE;
            learned.delete();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lzw_beat_t want;
        if (!rst_n)
        begin
            prefix      = '0;
            prefix_held = 1'b0;
            free_code   = LZW_FIRST_CODE;
            learned.delete();
            expected_codes.delete();
            beat_index  = 0;
            fail_count  = 0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
                encode_byte(bytes.data_byte, bytes.last_byte);
            if (codes.valid && codes.ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    report_mismatch($sformatf("code %0d final %0b with nothing expected",
                                              codes.out_code, codes.final_code));
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (codes.out_code !== want.out_code)
                        report_mismatch($sformatf("out_code %0d, expected %0d",
                                                  codes.out_code, want.out_code));
                    if (codes.final_code !== want.final_code)
                        report_mismatch($sformatf("final_code %0b, expected %0b",
                                                  codes.final_code, want.final_code));
                end
                beat_index++;
            end
        end
        outstanding = expected_codes.size();
    end

endmodule

>>> bench/lzw_encoder_12bit_tb.sv
`timescale 1ns / 1ps
// Top of the LZW encoder bench: clock, reset, byte and code stimulus, and the verdict.
module lzw_encoder_12bit_tb;
    import lzw_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 6;
    // Watchdog limit on the length of the whole run.
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 50;
    // Random bytes miss the dictionary almost every time, so one long message
    // keeps the encoder emitting and learning on nearly every byte.
    localparam int LONG_MSG_BYTES = 80;

    logic clk = 1'b0;
    logic rst_n;

    lzw_byte_if bytes_ch ();
    lzw_code_if codes_ch ();

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    // Idling controls, set by the main sequence and read by the two sides.
    bit source_idle_on = 1'b0;
    bit sink_idle_on   = 1'b0;
    bit hold_request   = 1'b0;

    lzw_encoder_12bit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_ch),
        .codes (codes_ch)
    );

    lzw_code_checker code_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes_ch),
        .codes       (codes_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost code ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one byte beat and hold it until the encoder takes it. Called at a
    // rising edge; returns at the edge where the beat was accepted, so a
    // following call keeps valid high unless source idling drops it first.
    task automatic send_byte(input logic [LZW_BYTE_W-1:0] b, input logic l);
        if (source_idle_on && $urandom_range(0, 3) == 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last_byte <= l;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
    endtask

    // Send one whole message drawn from a window of the byte range. Narrow
    // windows repeat pairs often, so the prefix climbs through long chains.
    task automatic send_message(input int len, input int alphabet);
        int i;
        int base;
        base = $urandom_range(0, 256 - alphabet);
        for (i = 0; i < len; i++)
            send_byte(LZW_BYTE_W'(base + $urandom_range(0, alphabet - 1)), i == len - 1);
    endtask

    // Random messages until roughly n_items bytes have gone in.
    task automatic run_random(input int n_items);
        int sent;
        int len;
        int alphabet;
        int pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                alphabet = 2;
            else if (pick < 6)
                alphabet = 4;
            else if (pick < 8)
                alphabet = 16;
            else
                alphabet = 256;
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(25, 80);
            else
                len = $urandom_range(1, 24);
            send_message(len, alphabet);
            sent += len;
        end
    endtask

    // Code sink: ready in random bursts, plus one long hold-off on request.
    initial
    begin : receiver
        codes_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                // Hold off long enough for the encoder to back up onto its input.
                hold_request = 1'b0;
                codes_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                codes_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            codes_ch.ready <= 1'b1;
        end
    end

    initial
    begin : main_sequence
        rst_n              <= 1'b0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= '0;
        bytes_ch.last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-byte messages at both ends of the byte range: the byte is the closing code.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // Repeated byte: a learned pair is hit and the prefix moves to code 256.
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);

        // Miss on the last byte: ordinary code first, closing code second.
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);

        // Alternating pair: learned codes chain on each other; fresh dictionary
        // again here, since the previous message dropped everything.
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b1);

        // Extremes side by side.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // Random messages with idling on both sides.
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        run_random(350);

        // Stall the sink for a long stretch while bytes keep coming.
        hold_request = 1'b1;
        run_random(150);

        // One long message of random bytes: a miss and a new entry on almost every byte.
        send_message(LONG_MSG_BYTES, 256);

        // Closing stretch at full rate, no idling on either side.
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        run_random(400);
        bytes_ch.valid <= 1'b0;

        // Drain: every predicted code must arrive; the watchdog covers a hang.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
